// ----- rtl/spad_pkg.sv -----
package spad_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FIELD_W         = 32;
  localparam int unsigned DIST_W          = 31;
  localparam int unsigned SHORT_LIMIT     = 50;
  localparam int unsigned UNIT_SCALE      = 1000;
  localparam int unsigned SCALE_SH        = 3;
  localparam int unsigned SCALE_ODD       = UNIT_SCALE >> SCALE_SH;
  localparam int unsigned SCALE_ODD_W     = 7;
  localparam int unsigned NORM_W          = 12;

  typedef struct packed {
    logic signed [FIELD_W-1:0] p_x;
    logic signed [FIELD_W-1:0] p_y;
    logic signed [FIELD_W-1:0] a_x;
    logic signed [FIELD_W-1:0] a_y;
    logic signed [FIELD_W-1:0] b_x;
    logic signed [FIELD_W-1:0] b_y;
    logic [DIST_W-1:0]         radius;
  } in_t;

  typedef struct packed {
    logic                      found;
    logic signed [FIELD_W-1:0] result_x;
    logic signed [FIELD_W-1:0] result_y;
  } out_t;

endpackage

// ----- rtl/spad_isqrt.sv -----
module spad_isqrt import spad_pkg::*; #(
  parameter int unsigned IN_W = 66,
  parameter int unsigned SB_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [IN_W-1:0]           rad_i,
  input  logic [SB_W-1:0]           sb_i,
  output logic                      valid_o,
  output logic [(IN_W+1)/2-1:0]     root_o,
  output logic [SB_W-1:0]           sb_o
);

  localparam int unsigned RT_W  = (IN_W + 1) / 2;
  localparam int unsigned PAD_W = 2 * RT_W;
  localparam int unsigned REM_W = RT_W + 2;

  logic [RT_W:0]      vld_q;
  logic [PAD_W-1:0]   rad_q  [RT_W+1];
  logic [REM_W-1:0]   rem_q  [RT_W+1];
  logic [RT_W-1:0]    root_q [RT_W+1];
  logic [SB_W-1:0]    sb_q   [RT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= PAD_W'(rad_i);
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    sb_q[0]   <= sb_i;
  end

  for (genvar k = 0; k < RT_W; k++) begin : g_step
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign sh    = {rem_q[k][REM_W-3:0], rad_q[k][PAD_W-1 -: 2]};
    assign trial = {root_q[k], 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k+1]  <= rad_q[k] << 2;
      rem_q[k+1]  <= ge ? (sh - trial) : sh;
      root_q[k+1] <= {root_q[k][RT_W-2:0], ge};
      sb_q[k+1]   <= sb_q[k];
    end
  end

  assign valid_o = vld_q[RT_W];
  assign root_o  = root_q[RT_W];
  assign sb_o    = sb_q[RT_W];

endmodule

// ----- rtl/spad_div.sv -----
module spad_div import spad_pkg::*; #(
  parameter int unsigned N_W  = 67,
  parameter int unsigned D_W  = 33,
  parameter int unsigned SB_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [N_W-1:0] num_i,
  input  logic [D_W-1:0]        den_i,
  input  logic [SB_W-1:0]       sb_i,
  output logic                  valid_o,
  output logic signed [N_W-1:0] quo_o,
  output logic [SB_W-1:0]       sb_o
);

  logic [N_W:0]      vld_q;
  logic [N_W-1:0]    num_q [N_W+1];
  logic [N_W-1:0]    quo_q [N_W+1];
  logic [D_W-1:0]    rem_q [N_W+1];
  logic [D_W-1:0]    den_q [N_W+1];
  logic              neg_q [N_W+1];
  logic [SB_W-1:0]   sb_q  [N_W+1];

  logic                  out_vld_q;
  logic signed [N_W-1:0] out_quo_q;
  logic [SB_W-1:0]       out_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0]  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q[0]  <= valid_i;
      out_vld_q <= vld_q[N_W];
    end
  end

  always_ff @(posedge clk_i) begin
    num_q[0]  <= num_i[N_W-1] ? N_W'(-num_i) : N_W'(num_i);
    neg_q[0]  <= num_i[N_W-1];
    quo_q[0]  <= '0;
    rem_q[0]  <= '0;
    den_q[0]  <= den_i;
    sb_q[0]   <= sb_i;
    out_quo_q <= neg_q[N_W] ? -$signed(quo_q[N_W]) : $signed(quo_q[N_W]);
    out_sb_q  <= sb_q[N_W];
  end

  for (genvar k = 0; k < N_W; k++) begin : g_step
    logic [D_W:0] sh;
    logic         ge;

    assign sh = {rem_q[k], num_q[k][N_W-1]};
    assign ge = (sh >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? D_W'(sh - {1'b0, den_q[k]}) : sh[D_W-1:0];
      num_q[k+1] <= num_q[k] << 1;
      quo_q[k+1] <= {quo_q[k][N_W-2:0], ge};
      den_q[k+1] <= den_q[k];
      neg_q[k+1] <= neg_q[k];
      sb_q[k+1]  <= sb_q[k];
    end
  end

  assign valid_o = out_vld_q;
  assign quo_o   = out_quo_q;
  assign sb_o    = out_sb_q;

endmodule

// ----- rtl/segment_point_at_distance.sv -----
// Point on segment a..b at distance radius from point p.
// Input channel: drive in_i and pulse start_i; a beat is taken at every
// clock edge with start_i high and busy_o low. busy_o stays low, so a new
// query may enter in every cycle and many queries are in flight at once.
// Output channel: done_o is high for exactly one cycle per query, in input
// order, with res_o valid in that cycle; the receiver cannot stall it.
// When no point exists, found is 0 and both coordinates are 0.
// Throughput is one query per cycle. The query passes a chain of units: the
// segment length root, the foot division by the length, the reciprocal
// scaling by 1000 for short segments, the two roots for the perpendicular
// and the chord, and the final scaling division; the roots and divisions
// resolve one bit per stage.
// Reset clears all valid bits in the pipeline; queries in flight are dropped
// and no done_o pulse follows reset until a new beat is taken.
module segment_point_at_distance import spad_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t  in_i,
  output logic busy_o,
  output logic done_o,
  output out_t res_o
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned DW    = W + 1;
  localparam int unsigned SQW   = 2 * W + 2;
  localparam int unsigned SW    = 2 * W + 3;
  localparam int unsigned RW    = W + 1;
  localparam int unsigned FW    = W + 3;
  localparam int unsigned F2W   = 2 * FW;
  localparam int unsigned SPW   = W + NORM_W + 2;
  localparam int unsigned TW    = ((FW > DIST_W) ? FW : DIST_W) + 2;
  localparam int unsigned CW    = (RW > DIST_W) ? RW : DIST_W;
  localparam int unsigned RAD2W = 2 * DIST_W;
  localparam int unsigned SUMW  = W + 2;

  localparam int unsigned MAG_W = SPW - 1;
  localparam int unsigned SCM_W = MAG_W - SCALE_SH;
  localparam int unsigned SCK   = SCM_W + SCALE_ODD_W;
  localparam int unsigned SCP_W = SCK + 1;
  localparam int unsigned RCP_W = SCM_W + 1;
  localparam int unsigned MLO_W = SCM_W / 2;
  localparam int unsigned MHI_W = SCM_W - MLO_W;
  localparam int unsigned RLO_W = RCP_W / 2;
  localparam int unsigned RHI_W = RCP_W - RLO_W;
  localparam int unsigned PP_W  = MHI_W + RHI_W;
  localparam int unsigned TOT_W = SCM_W + RCP_W;
  localparam int unsigned QW    = TOT_W - SCK;
  localparam logic [RCP_W-1:0] SC_RCP =
    RCP_W'(((SCP_W'(1) << SCK) + SCP_W'(SCALE_ODD - 1)) / SCP_W'(SCALE_ODD));

  typedef struct packed {
    logic signed [W-1:0]  ax;
    logic signed [W-1:0]  ay;
    logic signed [DW-1:0] abx;
    logic signed [DW-1:0] aby;
    logic signed [DW-1:0] apx;
    logic signed [DW-1:0] apy;
    logic [DIST_W-1:0]    rad;
    logic [SQW-1:0]       ap2;
    logic signed [SW-1:0] dot;
    logic [RW-1:0]        absz;
    logic                 zero;
    logic                 is_short;
    logic signed [FW-1:0] foot_long;
    logic signed [FW-1:0] foot;
    logic                 far;
    logic [RW-1:0]        t;
    logic                 found;
  } ctx_t;

  localparam int unsigned CTX_W = $bits(ctx_t);

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  logic s8_v_q, s9_v_q, s10_v_q, s11_v_q, s12_v_q, s13_v_q, s14_v_q, s15_v_q;
  logic sc1_v_q, sc2_v_q, sc3_v_q, sc4_v_q;

  ctx_t ctx1_q, ctx2_q, ctx3_q, ctx4_q, ctx5_q, ctx6_q, ctx7_q;
  ctx_t ctx8_q, ctx9_q, ctx10_q, ctx11_q, ctx12_q, ctx14_q;
  ctx_t ctx1_d, ctx3_d, ctx4_d, ctx5_d, ctx8_d, ctx11_d, ctx13_d, ctx13_q;
  ctx_t ctxs1_q, ctxs2_q, ctxs3_q, ctxs4_q;
  ctx_t ctx_out;

  logic signed [W-1:0] px_c, py_c, ax_c, ay_c, bx_c, by_c;

  logic signed [SW-1:0]     mabx_q, maby_q, mdx_q, mdy_q, mapx_q, mapy_q;
  logic [SQW-1:0]           ab2_q;
  logic [RW-1:0]            den4_q, den14_q;
  logic signed [SW-1:0]     nxn_q, nyn_q;
  logic signed [NORM_W-1:0] nx5_q, ny5_q;
  logic signed [SPW-1:0]    spx_q, spy_q, ssum_q;
  logic signed [F2W-1:0]    f2_q;
  logic [SQW-1:0]           diff_q;
  logic [RAD2W-1:0]         rr_q, hh_q, sd_q;
  logic signed [SW-1:0]     oxn_q, oyn_q;
  out_t                     res_q;

  logic                     neg1_q, neg2_q, neg3_q, neg4_q;
  logic [MAG_W-1:0]         mag_c;
  logic [SCM_W-1:0]         mag1_q;
  logic [PP_W-1:0]          pll_q, plh_q, phl_q, phh_q;
  logic [TOT_W-1:0]         sa_q, sb_q, tot_c;
  logic [QW-1:0]            q4_q;
  logic signed [FW-1:0]     qsc;

  logic              r1_v, r2_v, r3_v;
  logic [RW-1:0]     r1_root, r2_root;
  logic [DIST_W-1:0] r3_root;
  logic [CTX_W-1:0]  r1_sb, r2_sb, r3_sb;

  logic                 d1_v, d3_v;
  logic signed [SW-1:0] qdot, qnx, qny, qox, qoy;
  logic [CTX_W-1:0]     d1_sb, d3_sb;

  logic [DIST_W-1:0] h31;
  logic [SUMW-1:0]   sum_x, sum_y;

  assign px_c = $signed(W'($unsigned(in_i.p_x)));
  assign py_c = $signed(W'($unsigned(in_i.p_y)));
  assign ax_c = $signed(W'($unsigned(in_i.a_x)));
  assign ay_c = $signed(W'($unsigned(in_i.a_y)));
  assign bx_c = $signed(W'($unsigned(in_i.b_x)));
  assign by_c = $signed(W'($unsigned(in_i.b_y)));

  always_comb begin
    ctx1_d     = '0;
    ctx1_d.ax  = ax_c;
    ctx1_d.ay  = ay_c;
    ctx1_d.abx = DW'(bx_c) - DW'(ax_c);
    ctx1_d.aby = DW'(by_c) - DW'(ay_c);
    ctx1_d.apx = DW'(px_c) - DW'(ax_c);
    ctx1_d.apy = DW'(py_c) - DW'(ay_c);
    ctx1_d.rad = in_i.radius;
  end

  always_comb begin
    ctx3_d     = ctx2_q;
    ctx3_d.ap2 = SQW'(mapx_q + mapy_q);
    ctx3_d.dot = mdx_q + mdy_q;
  end

  always_comb begin
    ctx4_d          = ctx_t'(r1_sb);
    ctx4_d.absz     = r1_root;
    ctx4_d.zero     = (r1_root == '0);
    ctx4_d.is_short = (r1_root < RW'(SHORT_LIMIT));
  end

  always_comb begin
    ctx5_d           = ctx_t'(d1_sb);
    ctx5_d.foot_long = FW'(qdot);
  end

  assign mag_c = ssum_q[SPW-1] ? MAG_W'(-ssum_q) : MAG_W'(ssum_q);
  assign tot_c = sa_q + (sb_q << MLO_W);
  assign qsc   = neg4_q ? $signed(-FW'(q4_q)) : $signed(FW'(q4_q));

  always_comb begin
    ctx8_d      = ctxs4_q;
    ctx8_d.foot = ctx8_d.is_short ? qsc : ctx8_d.foot_long;
  end

  always_comb begin
    ctx11_d     = ctx_t'(r2_sb);
    ctx11_d.far = (CW'(r2_root) > CW'(ctx11_d.rad));
  end

  assign h31 = DIST_W'(r2_root);

  always_comb begin
    logic signed [TW-1:0] foot_e;
    logic signed [TW-1:0] s_e;
    logic signed [TW-1:0] len_e;
    logic signed [TW-1:0] t_lo;
    logic signed [TW-1:0] t_hi;
    logic signed [TW-1:0] t_sel;
    logic                 hit;
    ctx13_d = ctx_t'(r3_sb);
    foot_e  = TW'(ctx13_d.foot);
    s_e     = $signed(TW'(r3_root));
    len_e   = $signed(TW'(ctx13_d.absz));
    t_lo    = foot_e - s_e;
    t_hi    = foot_e + s_e;
    if (foot_e <= 0) begin
      t_sel = t_hi;
      hit   = (t_hi >= 0) && (t_hi <= len_e);
    end else if (foot_e >= len_e) begin
      t_sel = t_lo;
      hit   = (t_lo >= 0) && (t_lo <= len_e);
    end else if (t_lo >= 0) begin
      t_sel = t_lo;
      hit   = 1'b1;
    end else begin
      t_sel = t_hi;
      hit   = (t_hi < len_e);
    end
    ctx13_d.t     = RW'(t_sel);
    ctx13_d.found = hit && !ctx13_d.far;
  end

  assign ctx_out = ctx_t'(d3_sb);
  assign sum_x   = SUMW'(ctx_out.ax) + SUMW'(qox);
  assign sum_y   = SUMW'(ctx_out.ay) + SUMW'(qoy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      sc1_v_q <= 1'b0;
      sc2_v_q <= 1'b0;
      sc3_v_q <= 1'b0;
      sc4_v_q <= 1'b0;
      s8_v_q  <= 1'b0;
      s9_v_q  <= 1'b0;
      s10_v_q <= 1'b0;
      s11_v_q <= 1'b0;
      s12_v_q <= 1'b0;
      s13_v_q <= 1'b0;
      s14_v_q <= 1'b0;
      s15_v_q <= 1'b0;
    end else begin
      s1_v_q  <= start_i && !busy_o;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= r1_v;
      s5_v_q  <= d1_v;
      s6_v_q  <= s5_v_q;
      s7_v_q  <= s6_v_q;
      sc1_v_q <= s7_v_q;
      sc2_v_q <= sc1_v_q;
      sc3_v_q <= sc2_v_q;
      sc4_v_q <= sc3_v_q;
      s8_v_q  <= sc4_v_q;
      s9_v_q  <= s8_v_q;
      s10_v_q <= s9_v_q;
      s11_v_q <= r2_v;
      s12_v_q <= s11_v_q;
      s13_v_q <= r3_v;
      s14_v_q <= s13_v_q;
      s15_v_q <= d3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx1_q  <= ctx1_d;

    ctx2_q  <= ctx1_q;
    mabx_q  <= SW'(ctx1_q.abx) * SW'(ctx1_q.abx);
    maby_q  <= SW'(ctx1_q.aby) * SW'(ctx1_q.aby);
    mdx_q   <= SW'(ctx1_q.abx) * SW'(ctx1_q.apx);
    mdy_q   <= SW'(ctx1_q.aby) * SW'(ctx1_q.apy);
    mapx_q  <= SW'(ctx1_q.apx) * SW'(ctx1_q.apx);
    mapy_q  <= SW'(ctx1_q.apy) * SW'(ctx1_q.apy);

    ctx3_q  <= ctx3_d;
    ab2_q   <= SQW'(mabx_q + maby_q);

    ctx4_q  <= ctx4_d;
    den4_q  <= ctx4_d.zero ? RW'(1) : r1_root;
    nxn_q   <= SW'(ctx4_d.abx) * $signed(SW'(UNIT_SCALE));
    nyn_q   <= SW'(ctx4_d.aby) * $signed(SW'(UNIT_SCALE));

    ctx5_q  <= ctx5_d;
    nx5_q   <= ctx5_d.zero ? $signed(NORM_W'(UNIT_SCALE)) : NORM_W'(qnx);
    ny5_q   <= ctx5_d.zero ? '0 : NORM_W'(qny);

    ctx6_q  <= ctx5_q;
    spx_q   <= SPW'(nx5_q) * SPW'(ctx5_q.apx);
    spy_q   <= SPW'(ny5_q) * SPW'(ctx5_q.apy);

    ctx7_q  <= ctx6_q;
    ssum_q  <= spx_q + spy_q;

    ctxs1_q <= ctx7_q;
    neg1_q  <= ssum_q[SPW-1];
    mag1_q  <= mag_c[MAG_W-1:SCALE_SH];

    ctxs2_q <= ctxs1_q;
    neg2_q  <= neg1_q;
    pll_q   <= PP_W'(mag1_q[MLO_W-1:0]) * PP_W'(SC_RCP[RLO_W-1:0]);
    plh_q   <= PP_W'(mag1_q[MLO_W-1:0]) * PP_W'(SC_RCP[RCP_W-1:RLO_W]);
    phl_q   <= PP_W'(mag1_q[SCM_W-1:MLO_W]) * PP_W'(SC_RCP[RLO_W-1:0]);
    phh_q   <= PP_W'(mag1_q[SCM_W-1:MLO_W]) * PP_W'(SC_RCP[RCP_W-1:RLO_W]);

    ctxs3_q <= ctxs2_q;
    neg3_q  <= neg2_q;
    sa_q    <= TOT_W'(pll_q) + (TOT_W'(plh_q) << RLO_W);
    sb_q    <= TOT_W'(phl_q) + (TOT_W'(phh_q) << RLO_W);

    ctxs4_q <= ctxs3_q;
    neg4_q  <= neg3_q;
    q4_q    <= tot_c[TOT_W-1:SCK];

    ctx8_q  <= ctx8_d;

    ctx9_q  <= ctx8_q;
    f2_q    <= F2W'(ctx8_q.foot) * F2W'(ctx8_q.foot);

    ctx10_q <= ctx9_q;
    diff_q  <= ($unsigned(f2_q) > F2W'(ctx9_q.ap2)) ? '0
             : (ctx9_q.ap2 - SQW'($unsigned(f2_q)));

    ctx11_q <= ctx11_d;
    rr_q    <= RAD2W'(ctx11_d.rad) * RAD2W'(ctx11_d.rad);
    hh_q    <= RAD2W'(h31) * RAD2W'(h31);

    ctx12_q <= ctx11_q;
    sd_q    <= rr_q - hh_q;

    ctx13_q <= ctx13_d;

    ctx14_q <= ctx13_q;
    den14_q <= ctx13_q.zero ? RW'(1) : ctx13_q.absz;
    oxn_q   <= SW'(ctx13_q.abx) * $signed(SW'(ctx13_q.t));
    oyn_q   <= SW'(ctx13_q.aby) * $signed(SW'(ctx13_q.t));

    res_q.found    <= ctx_out.found;
    res_q.result_x <= ctx_out.found ? FIELD_W'($signed(sum_x)) : '0;
    res_q.result_y <= ctx_out.found ? FIELD_W'($signed(sum_y)) : '0;
  end

  spad_isqrt #(.IN_W(SQW), .SB_W(CTX_W)) u_root_len (
    .clk_i, .rst_ni,
    .valid_i (s3_v_q),
    .rad_i   (ab2_q),
    .sb_i    (ctx3_q),
    .valid_o (r1_v),
    .root_o  (r1_root),
    .sb_o    (r1_sb)
  );

  spad_div #(.N_W(SW), .D_W(RW), .SB_W(CTX_W)) u_div_foot (
    .clk_i, .rst_ni,
    .valid_i (s4_v_q),
    .num_i   (ctx4_q.dot),
    .den_i   (den4_q),
    .sb_i    (ctx4_q),
    .valid_o (d1_v),
    .quo_o   (qdot),
    .sb_o    (d1_sb)
  );

  spad_div #(.N_W(SW), .D_W(RW), .SB_W(1)) u_div_nx (
    .clk_i, .rst_ni,
    .valid_i (s4_v_q),
    .num_i   (nxn_q),
    .den_i   (den4_q),
    .sb_i    (1'b0),
    .valid_o (),
    .quo_o   (qnx),
    .sb_o    ()
  );

  spad_div #(.N_W(SW), .D_W(RW), .SB_W(1)) u_div_ny (
    .clk_i, .rst_ni,
    .valid_i (s4_v_q),
    .num_i   (nyn_q),
    .den_i   (den4_q),
    .sb_i    (1'b0),
    .valid_o (),
    .quo_o   (qny),
    .sb_o    ()
  );

  spad_isqrt #(.IN_W(SQW), .SB_W(CTX_W)) u_root_perp (
    .clk_i, .rst_ni,
    .valid_i (s10_v_q),
    .rad_i   (diff_q),
    .sb_i    (ctx10_q),
    .valid_o (r2_v),
    .root_o  (r2_root),
    .sb_o    (r2_sb)
  );

  spad_isqrt #(.IN_W(RAD2W), .SB_W(CTX_W)) u_root_chord (
    .clk_i, .rst_ni,
    .valid_i (s12_v_q),
    .rad_i   (sd_q),
    .sb_i    (ctx12_q),
    .valid_o (r3_v),
    .root_o  (r3_root),
    .sb_o    (r3_sb)
  );

  spad_div #(.N_W(SW), .D_W(RW), .SB_W(CTX_W)) u_div_ox (
    .clk_i, .rst_ni,
    .valid_i (s14_v_q),
    .num_i   (oxn_q),
    .den_i   (den14_q),
    .sb_i    (ctx14_q),
    .valid_o (d3_v),
    .quo_o   (qox),
    .sb_o    (d3_sb)
  );

  spad_div #(.N_W(SW), .D_W(RW), .SB_W(1)) u_div_oy (
    .clk_i, .rst_ni,
    .valid_i (s14_v_q),
    .num_i   (oyn_q),
    .den_i   (den14_q),
    .sb_i    (1'b0),
    .valid_o (),
    .quo_o   (qoy),
    .sb_o    ()
  );

  assign busy_o = 1'b0;
  assign done_o = s15_v_q;
  assign res_o  = res_q;

endmodule

// ----- bench/segment_point_at_distance_checker.sv -----
module segment_point_at_distance_checker import spad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  in_t  in_i,
  input  logic done_i,
  input  out_t res_i,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  out_t expected_points[$];

  function automatic wide_t floor_root(wide_t n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= $unsigned(n)) r = c;
    end
    return $signed(r);
  endfunction

  function automatic out_t point_at_distance(in_t q);
    wide_t ax, ay, abx, aby, apx, apy, len, foot, nx, ny, ap2, f2, diff;
    wide_t h, s, rad, t, ox, oy;
    logic hit;
    out_t r;
    ax   = q.a_x;
    ay   = q.a_y;
    abx  = wide_t'(q.b_x) - ax;
    aby  = wide_t'(q.b_y) - ay;
    apx  = wide_t'(q.p_x) - ax;
    apy  = wide_t'(q.p_y) - ay;
    rad  = wide_t'({97'd0, q.radius});
    len  = floor_root(abx * abx + aby * aby);
    if (len < SHORT_LIMIT) begin
      if (len == 0) begin
        nx = UNIT_SCALE;
        ny = 0;
      end else begin
        nx = abx * wide_t'(UNIT_SCALE) / len;
        ny = aby * wide_t'(UNIT_SCALE) / len;
      end
      foot = (nx * apx + ny * apy) / wide_t'(UNIT_SCALE);
    end else begin
      foot = (abx * apx + aby * apy) / len;
    end
    ap2  = apx * apx + apy * apy;
    f2   = foot * foot;
    diff = (f2 > ap2) ? wide_t'(0) : ap2 - f2;
    h    = floor_root(diff);
    r    = '0;
    hit  = 1'b0;
    t    = 0;
    if (h <= rad) begin
      s = floor_root(rad * rad - h * h);
      if (foot <= 0) begin
        t   = foot + s;
        hit = (t >= 0) && (t <= len);
      end else if (foot >= len) begin
        t   = foot - s;
        hit = (t >= 0) && (t <= len);
      end else begin
        t = foot - s;
        if (t >= 0) begin
          hit = 1'b1;
        end else begin
          t   = foot + s;
          hit = (t < len);
        end
      end
    end
    if (hit) begin
      if (len == 0) begin
        ox = t;
        oy = 0;
      end else begin
        ox = abx * t / len;
        oy = aby * t / len;
      end
      r.found    = 1'b1;
      r.result_x = FIELD_W'(ax + ox);
      r.result_y = FIELD_W'(ay + oy);
    end
    return r;
  endfunction

  assign pending_o = expected_points.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      errors_o = 0;
      expected_points.delete();
    end else begin
      if (done_i) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result %p", $time, res_i);
          errors_o++;
        end else begin
          want = expected_points.pop_front();
          if (want.found !== res_i.found)
            $display("%0t: found expected %0b actual %0b", $time, want.found, res_i.found);
          if (want.result_x !== res_i.result_x)
            $display("%0t: result_x expected %0d actual %0d", $time,
                     want.result_x, res_i.result_x);
          if (want.result_y !== res_i.result_y)
            $display("%0t: result_y expected %0d actual %0d", $time,
                     want.result_y, res_i.result_y);
          if (want !== res_i) errors_o++;
        end
      end
      if (start_i && !busy_i) expected_points.push_back(point_at_distance(in_i));
    end
  end

endmodule

// ----- bench/segment_point_at_distance_tb.sv -----
module segment_point_at_distance_tb import spad_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int N_RANDOM   = 1380;

  logic clk_i, rst_ni, start_i, busy_o, done_o;
  in_t  in_i;
  out_t res_o;
  int   errors, pending, idle_cycles;

  segment_point_at_distance dut (
    .clk_i, .rst_ni, .start_i, .in_i, .busy_o, .done_o, .res_o
  );

  segment_point_at_distance_checker checker_u (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_i, .done_i(done_o), .res_i(res_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(in_t q);
    @(negedge clk_i);
    start_i <= 1'b1;
    in_i    <= q;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic hold_off();
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  function automatic in_t make_query(int px, int py, int ax, int ay, int bx, int by,
                                     int unsigned rad);
    in_t q;
    q.p_x = px; q.p_y = py; q.a_x = ax; q.a_y = ay; q.b_x = bx; q.b_y = by;
    q.radius = rad[DIST_W-1:0];
    return q;
  endfunction

  function automatic int coord(int span);
    if (span == 0) return $urandom;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic in_t random_query();
    int spans[4] = '{60, 20000, 3000000, 0};
    int span;
    in_t q;
    span = spans[$urandom_range(0, 3)];
    q.p_x = coord(span); q.p_y = coord(span);
    q.a_x = coord(span); q.a_y = coord(span);
    if ($urandom_range(0, 9) == 0) begin
      q.b_x = q.a_x + int'($urandom_range(0, 60)) - 30;
      q.b_y = q.a_y + int'($urandom_range(0, 60)) - 30;
    end else begin
      q.b_x = coord(span); q.b_y = coord(span);
    end
    if (span == 0 || $urandom_range(0, 7) == 0)
      q.radius = DIST_W'($urandom);
    else
      q.radius = DIST_W'($urandom_range(0, 3 * span));
    return q;
  endfunction

  initial begin
    int mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    in_i    = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send(make_query(0, 0, 0, 0, 0, 0, 0));
    send(make_query(5, 0, 0, 0, 0, 0, 5));
    send(make_query(mx, mx, mn, mn, mx, mx, 32'h7fffffff));
    send(make_query(mn, mx, mx, mn, mn, mx, 32'h7fffffff));
    send(make_query(mn, mn, mn, mn, mx, mx, 0));
    send(make_query(mx, mn, mn, mx, mx, mn, 1));
    send(make_query(0, 100, 0, 0, 1000, 0, 50));
    send(make_query(-50, 0, 0, 0, 1000, 0, 80));
    send(make_query(1200, 0, 0, 0, 1000, 0, 250));
    send(make_query(500, 10, 0, 0, 1000, 0, 100));
    send(make_query(20, 3, 0, 0, 1000, 0, 100));
    send(make_query(980, 3, 0, 0, 1000, 0, 100));
    send(make_query(500, 0, 0, 0, 1000, 0, 2000));
    send(make_query(3, 7, 0, 0, 10, 20, 5));
    send(make_query(-4, 2, 1, 1, -30, -12, 9));
    send(make_query(0, 0, 10, 10, 10, 10, 15));
    send(make_query(1, 2, 3, 4, 3, 4, 2));
    send(make_query(0, 0, 0, 0, 49, 0, 49));
    send(make_query(0, 0, 0, 0, 50, 0, 50));
    send(make_query(-7, -7, -100, 300, 400, -200, 333));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 800) begin
        hold_off();
        wait (pending == 0);
      end
      if ((i < 400 || i > 700) && $urandom_range(0, 99) < 10) begin
        hold_off();
      end
      send(random_query());
    end
    hold_off();

    wait (pending == 0);
    repeat (320) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
